// ===== hw/rtl/time_to_collision_two_agents_top_assert.svh =====
// Assertion macros for the time-to-collision block.
// Used by time_to_collision_two_agents_top; no other dependencies.
`ifndef TIME_TO_COLLISION_TWO_AGENTS_TOP_ASSERT_SVH
`define TIME_TO_COLLISION_TWO_AGENTS_TOP_ASSERT_SVH

// same-cycle implication, off during reset
`define TTC_AST_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// fixed-delay implication, off during reset
`define TTC_AST_DLY(lbl, clk, rstn, ante, dly, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> ##dly (cons)) \
    else $error(msg);

// next-cycle implication, always on
`define TTC_AST_NXT(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/ttc_pkg.sv =====
// Shared types and constants for the time-to-collision pipeline.
// No dependencies; used by ttc_sine, ttc_solve and the top level.
package ttc_pkg;

  localparam int NUM_W  = 80;
  localparam int DEN_W  = 62;
  localparam int DISC_W = 116;
  localparam int ROOT_W = 58;
  localparam int REM_W  = 60;
  localparam int QUO_W  = 32;

  localparam logic [30:0] SIN_A = 31'd1686629713;
  localparam logic [29:0] SIN_B = 30'd688904866;
  localparam logic [26:0] SIN_C = 27'd76016977;

  typedef enum logic [1:0] {
    ST_FINITE = 2'b00,
    ST_NOW    = 2'b01,
    ST_NONE   = 2'b10
  } ttc_status_t;

  typedef struct packed {
    logic              do_div;
    logic              use_root;
    logic              neg;
    ttc_status_t       status;
    logic [NUM_W-1:0]  num;
    logic [DEN_W-1:0]  den;
    logic [DISC_W-1:0] disc;
  } ttc_req_t;

endpackage

// ===== hw/rtl/time_to_collision_two_agents_top.sv =====
// Top level of the two-agent time-to-collision pipeline.
// Depends on ttc_pkg, ttc_sine, ttc_solve and the assertion macro header.
//
//   channel   | handshake             | payload
//   ----------+-----------------------+-----------------------------------------
//   request   | start / busy          | in_own_*, in_other_* (x, y, speed, heading)
//   result    | out_valid (strobe)    | out_collision_time, out_ttc_status
//   config    | cfg_valid / cfg_ready | cfg_collision_distance
//
// One request per cycle; busy is never raised.
// Each result passes through 14 front stages (sine, velocity, products,
// quadratic terms), 58 square-root stages, 2 divisor stages, 32 divider
// stages and the output register.
// Synchronous active-low reset empties the pipeline and clears the distance.
`include "time_to_collision_two_agents_top_assert.svh"

module time_to_collision_two_agents_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_own_x,
  input  logic signed [31:0] in_own_y,
  input  logic [23:0]        in_own_speed,
  input  logic [15:0]        in_own_heading,
  input  logic signed [31:0] in_other_x,
  input  logic signed [31:0] in_other_y,
  input  logic [23:0]        in_other_speed,
  input  logic [15:0]        in_other_heading,
  output logic               out_valid,
  output logic signed [31:0] out_collision_time,
  output logic [1:0]         out_ttc_status,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [23:0]        cfg_collision_distance
);

  localparam int LATENCY = 107;

  typedef struct packed {
    logic [50:0] a;
    logic [57:0] habs;
    logic [63:0] cabs;
    logic        a_zero;
    logic        h_neg;
    logic        h_zero;
    logic        c_neg;
    logic        c_zero;
  } sol_t;

  function automatic logic signed [31:0] sat_diff(input logic signed [31:0] lhs,
                                                  input logic signed [31:0] rhs);
    logic signed [32:0] d;
    begin
      d = 33'(rhs) - 33'(lhs);
      if (d > 33'sd2147483647) begin
        sat_diff = 32'sh7FFFFFFF;
      end else if (d < -33'sd2147483647) begin
        sat_diff = 32'sh80000001;
      end else begin
        sat_diff = d[31:0];
      end
    end
  endfunction

  logic        accept;
  logic [23:0] cd_r;
  logic        vld_r [1:14];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cd_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      cd_r <= cfg_collision_distance;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 1; i <= 14; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else begin
      vld_r[1] <= accept;
      for (int i = 2; i <= 14; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
    end
  end

  // stage 1: position deltas, headings; lanes are own cos/sin, other cos/sin
  logic signed [31:0] dx_p_r [1:7];
  logic signed [31:0] dy_p_r [1:7];
  logic [23:0]        spd_own_p_r [1:5];
  logic [23:0]        spd_oth_p_r [1:5];
  logic [15:0]        ang_r [4];

  always_ff @(posedge clk) begin
    dx_p_r[1]      <= sat_diff(in_own_x, in_other_x);
    dy_p_r[1]      <= sat_diff(in_own_y, in_other_y);
    spd_own_p_r[1] <= in_own_speed;
    spd_oth_p_r[1] <= in_other_speed;
    ang_r[0]       <= in_own_heading + 16'd16384;
    ang_r[1]       <= in_own_heading;
    ang_r[2]       <= in_other_heading + 16'd16384;
    ang_r[3]       <= in_other_heading;
    for (int i = 2; i <= 7; i++) begin
      dx_p_r[i] <= dx_p_r[i-1];
      dy_p_r[i] <= dy_p_r[i-1];
    end
    for (int i = 2; i <= 5; i++) begin
      spd_own_p_r[i] <= spd_own_p_r[i-1];
      spd_oth_p_r[i] <= spd_oth_p_r[i-1];
    end
  end

  // stages 2-5: sine; stage 6: velocity components
  logic signed [25:0] vel_r [4];

  for (genvar i = 0; i < 4; i++) begin : g_lane
    logic [30:0] mag;
    logic        neg;
    logic [23:0] spd;
    logic [54:0] vp;
    logic signed [25:0] vs;
    ttc_sine u_sine (
      .clk (clk),
      .ang (ang_r[i]),
      .mag (mag),
      .neg (neg)
    );
    assign spd = (i < 2) ? spd_own_p_r[5] : spd_oth_p_r[5];
    assign vp  = 55'(spd) * 55'(mag);
    assign vs  = $signed({2'b00, vp[53:30]});
    always_ff @(posedge clk) begin
      vel_r[i] <= neg ? -vs : vs;
    end
  end

  // stage 7: relative velocity
  logic signed [25:0] dvx_r, dvy_r;

  always_ff @(posedge clk) begin
    dvx_r <= vel_r[2] - vel_r[0];
    dvy_r <= vel_r[3] - vel_r[1];
  end

  // stage 8: products
  logic signed [57:0] p_hx_r, p_hy_r;
  logic signed [51:0] p_vx_r, p_vy_r;
  logic signed [63:0] p_xx_r, p_yy_r;
  logic [47:0]        cd2_r;

  always_ff @(posedge clk) begin
    p_hx_r <= 58'(dx_p_r[7]) * 58'(dvx_r);
    p_hy_r <= 58'(dy_p_r[7]) * 58'(dvy_r);
    p_vx_r <= 52'(dvx_r) * 52'(dvx_r);
    p_vy_r <= 52'(dvy_r) * 52'(dvy_r);
    p_xx_r <= 64'(dx_p_r[7]) * 64'(dx_p_r[7]);
    p_yy_r <= 64'(dy_p_r[7]) * 64'(dy_p_r[7]);
    cd2_r  <= 48'(cd_r) * 48'(cd_r);
  end

  // stage 9: quadratic terms
  logic [50:0]        a_r;
  logic signed [57:0] h_r;
  logic signed [63:0] c_r;

  always_ff @(posedge clk) begin
    a_r <= 51'(p_vx_r[49:0]) + 51'(p_vy_r[49:0]);
    h_r <= p_hx_r + p_hy_r;
    c_r <= p_xx_r + p_yy_r - $signed(64'(cd2_r));
  end

  // stage 10: magnitudes and signs; carried to stage 13
  sol_t sol_nxt;
  sol_t sol_p_r [10:13];

  always_comb begin
    sol_nxt.a      = a_r;
    sol_nxt.habs   = h_r[57] ? $unsigned(-h_r) : $unsigned(h_r);
    sol_nxt.cabs   = c_r[63] ? $unsigned(-c_r) : $unsigned(c_r);
    sol_nxt.a_zero = (a_r == '0);
    sol_nxt.h_neg  = h_r[57];
    sol_nxt.h_zero = (h_r == '0);
    sol_nxt.c_neg  = c_r[63];
    sol_nxt.c_zero = (c_r == '0);
  end

  always_ff @(posedge clk) begin
    sol_p_r[10] <= sol_nxt;
    for (int i = 11; i <= 13; i++) begin
      sol_p_r[i] <= sol_p_r[i-1];
    end
  end

  // stage 11: partial products of h^2 and a*|c|
  logic [57:0] hh_ll_r, hh_lh_r, hh_hh_r;
  logic [63:0] ac_ll_r, ac_lh_r;
  logic [50:0] ac_hl_r, ac_hh_r;

  always_ff @(posedge clk) begin
    hh_ll_r <= 58'(sol_p_r[10].habs[28:0]) * 58'(sol_p_r[10].habs[28:0]);
    hh_lh_r <= 58'(sol_p_r[10].habs[28:0]) * 58'(sol_p_r[10].habs[57:29]);
    hh_hh_r <= 58'(sol_p_r[10].habs[57:29]) * 58'(sol_p_r[10].habs[57:29]);
    ac_ll_r <= 64'(sol_p_r[10].a[31:0]) * 64'(sol_p_r[10].cabs[31:0]);
    ac_lh_r <= 64'(sol_p_r[10].a[31:0]) * 64'(sol_p_r[10].cabs[63:32]);
    ac_hl_r <= 51'(sol_p_r[10].a[50:32]) * 51'(sol_p_r[10].cabs[31:0]);
    ac_hh_r <= 51'(sol_p_r[10].a[50:32]) * 51'(sol_p_r[10].cabs[63:32]);
  end

  // stage 12: full products
  logic [115:0] hh_r, ac_r;

  always_ff @(posedge clk) begin
    hh_r <= (116'(hh_hh_r) << 58) + (116'(hh_lh_r) << 30) + 116'(hh_ll_r);
    ac_r <= (116'(ac_hh_r) << 64) + ((116'(ac_lh_r) + 116'(ac_hl_r)) << 32)
            + 116'(ac_ll_r);
  end

  // stage 13: quarter discriminant
  logic [116:0] diff;
  logic [115:0] disc_r;
  logic         gt_r, eq_r;

  assign diff = {1'b0, hh_r} - {1'b0, ac_r};

  always_ff @(posedge clk) begin
    if (sol_p_r[12].c_neg) begin
      disc_r <= hh_r + ac_r;
      gt_r   <= 1'b1;
      eq_r   <= 1'b0;
    end else begin
      disc_r <= diff[115:0];
      gt_r   <= !diff[116] && (diff != '0);
      eq_r   <= (hh_r == ac_r);
    end
  end

  // stage 14: case decision and divider request
  ttc_pkg::ttc_req_t req_nxt, req_r;
  sol_t              s;
  logic              h_pos, c_pos;

  assign s     = sol_p_r[13];
  assign h_pos = !s.h_neg && !s.h_zero;
  assign c_pos = !s.c_neg && !s.c_zero;

  always_comb begin
    req_nxt.do_div   = 1'b0;
    req_nxt.use_root = 1'b0;
    req_nxt.neg      = 1'b0;
    req_nxt.status   = ttc_pkg::ST_NONE;
    req_nxt.num      = {s.cabs, 16'd0};
    req_nxt.den      = ttc_pkg::DEN_W'(s.habs);
    req_nxt.disc     = disc_r;
    if (s.a_zero) begin
      if (!s.h_zero) begin
        req_nxt.do_div = 1'b1;
        req_nxt.status = ttc_pkg::ST_FINITE;
        req_nxt.den    = ttc_pkg::DEN_W'({s.habs, 1'b0});
        req_nxt.neg    = !s.c_zero && (c_pos == h_pos);
      end
    end else if (eq_r) begin
      req_nxt.do_div = 1'b1;
      req_nxt.status = ttc_pkg::ST_FINITE;
      req_nxt.num    = ttc_pkg::NUM_W'({s.habs, 16'd0});
      req_nxt.den    = ttc_pkg::DEN_W'(s.a);
      req_nxt.neg    = h_pos;
    end else if (gt_r) begin
      if (h_pos && c_pos) begin
        req_nxt.status = ttc_pkg::ST_NONE;
      end else if (!s.h_neg || s.c_neg) begin
        req_nxt.status = ttc_pkg::ST_NOW;
      end else begin
        req_nxt.do_div   = 1'b1;
        req_nxt.use_root = 1'b1;
        req_nxt.status   = ttc_pkg::ST_FINITE;
      end
    end
  end

  always_ff @(posedge clk) begin
    req_r <= req_nxt;
  end

  ttc_pkg::ttc_status_t res_status;

  ttc_solve u_solve (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_vld    (vld_r[14]),
    .req        (req_r),
    .res_vld    (out_valid),
    .res_time   (out_collision_time),
    .res_status (res_status)
  );

  assign out_ttc_status = res_status;

  `TTC_AST_IMP(a_time_zero, clk, rst_n, out_valid && (out_ttc_status != ttc_pkg::ST_FINITE), out_collision_time == 32'sd0, "time not zero for non-finite status")
  `TTC_AST_DLY(a_latency, clk, rst_n, accept, LATENCY, out_valid, "result missing after pipeline latency")
  `TTC_AST_NXT(a_reset_quiet, clk, !rst_n, !out_valid, "strobe right after reset")

endmodule

// ===== hw/rtl/ttc_sine.sv =====
// Four-stage pipelined sine magnitude, Q1.30, from a 16-bit turn fraction.
// Depends on ttc_pkg for the polynomial coefficients.
module ttc_sine (
  input  logic        clk,
  input  logic [15:0] ang,
  output logic [30:0] mag,
  output logic        neg
);

  logic [14:0] x_in;
  logic [29:0] xx;
  logic [14:0] x1_r, x2_r, x3_r;
  logic [30:0] sq1_r, sq2_r;
  logic [29:0] t1_r;
  logic [30:0] t2_r;
  logic        neg1_r, neg2_r, neg3_r, neg_r;
  logic [30:0] mag_r;
  logic [57:0] p2;
  logic [60:0] p3;
  logic [45:0] p4;

  assign x_in = ang[14] ? (15'd16384 - {1'b0, ang[13:0]}) : {1'b0, ang[13:0]};
  assign xx   = 30'(x_in) * 30'(x_in);
  assign p2   = 58'(ttc_pkg::SIN_C) * 58'(sq1_r);
  assign p3   = 61'(sq2_r) * 61'(t1_r);
  assign p4   = 46'(x3_r) * 46'(t2_r);

  always_ff @(posedge clk) begin
    x1_r   <= x_in;
    sq1_r  <= {xx[28:0], 2'b00};
    neg1_r <= ang[15];
    x2_r   <= x1_r;
    sq2_r  <= sq1_r;
    t1_r   <= ttc_pkg::SIN_B - {2'b00, p2[57:30]};
    neg2_r <= neg1_r;
    x3_r   <= x2_r;
    t2_r   <= ttc_pkg::SIN_A - p3[60:30];
    neg3_r <= neg2_r;
    mag_r  <= p4[44:14];
    neg_r  <= neg3_r;
  end

  assign mag = mag_r;
  assign neg = neg_r;

endmodule

// ===== hw/rtl/ttc_solve.sv =====
// Pipelined floor square root, quotient and saturation for the collision time.
// Depends on ttc_pkg (request struct, widths, status codes).
module ttc_solve (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     req_vld,
  input  ttc_pkg::ttc_req_t        req,
  output logic                     res_vld,
  output logic signed [31:0]       res_time,
  output ttc_pkg::ttc_status_t     res_status
);

  localparam int SQ_N  = ttc_pkg::ROOT_W;
  localparam int DIV_N = ttc_pkg::QUO_W;
  localparam int DEN_W = ttc_pkg::DEN_W;
  localparam int QUO_W = ttc_pkg::QUO_W;

  typedef struct packed {
    logic                do_div;
    logic                neg;
    logic                ovf;
    ttc_pkg::ttc_status_t status;
    logic [DEN_W-1:0]    den;
  } div_ctl_t;

  // square root stages
  logic                         sq_vld_r  [SQ_N];
  ttc_pkg::ttc_req_t            sq_req_r  [SQ_N];
  logic [ttc_pkg::REM_W-1:0]    sq_rem_r  [SQ_N];
  logic [ttc_pkg::ROOT_W-1:0]   sq_root_r [SQ_N];
  logic [ttc_pkg::DISC_W-1:0]   sq_n_r    [SQ_N];

  for (genvar k = 0; k < SQ_N; k++) begin : g_sq
    logic                       vld_i, ge;
    ttc_pkg::ttc_req_t          req_i;
    logic [ttc_pkg::REM_W-1:0]  rem_i, rem2, trial;
    logic [ttc_pkg::ROOT_W-1:0] root_i;
    logic [ttc_pkg::DISC_W-1:0] n_i;
    if (k == 0) begin : g_first
      assign vld_i  = req_vld;
      assign req_i  = req;
      assign rem_i  = '0;
      assign root_i = '0;
      assign n_i    = req.disc;
    end else begin : g_next
      assign vld_i  = sq_vld_r[k-1];
      assign req_i  = sq_req_r[k-1];
      assign rem_i  = sq_rem_r[k-1];
      assign root_i = sq_root_r[k-1];
      assign n_i    = sq_n_r[k-1];
    end
    assign rem2  = {rem_i[ttc_pkg::REM_W-3:0], n_i[ttc_pkg::DISC_W-1 -: 2]};
    assign trial = {root_i, 2'b01};
    assign ge    = rem2 >= trial;
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_vld_r[k] <= 1'b0;
      end else begin
        sq_vld_r[k] <= vld_i;
      end
    end
    always_ff @(posedge clk) begin
      sq_req_r[k]  <= req_i;
      sq_rem_r[k]  <= ge ? (rem2 - trial) : rem2;
      sq_root_r[k] <= {root_i[ttc_pkg::ROOT_W-2:0], ge};
      sq_n_r[k]    <= {n_i[ttc_pkg::DISC_W-3:0], 2'b00};
    end
  end

  // divisor completion, then overflow check and remainder seed
  logic              a_vld_r, b_vld_r;
  ttc_pkg::ttc_req_t a_req_r;
  logic [DEN_W-1:0]  a_den_r;
  div_ctl_t          b_ctl_r;
  logic [DEN_W-1:0]  b_rem_r;
  logic [QUO_W-1:0]  b_nlo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
    end else begin
      a_vld_r <= sq_vld_r[SQ_N-1];
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    a_req_r <= sq_req_r[SQ_N-1];
    a_den_r <= sq_req_r[SQ_N-1].use_root ?
               sq_req_r[SQ_N-1].den + DEN_W'(sq_root_r[SQ_N-1]) : sq_req_r[SQ_N-1].den;
    b_ctl_r.do_div <= a_req_r.do_div;
    b_ctl_r.neg    <= a_req_r.neg;
    b_ctl_r.status <= a_req_r.status;
    b_ctl_r.den    <= a_den_r;
    b_ctl_r.ovf    <= DEN_W'(a_req_r.num[ttc_pkg::NUM_W-1:QUO_W]) >= a_den_r;
    b_rem_r        <= DEN_W'(a_req_r.num[ttc_pkg::NUM_W-1:QUO_W]);
    b_nlo_r        <= a_req_r.num[QUO_W-1:0];
  end

  // restoring division, one quotient bit per stage
  logic             dv_vld_r [DIV_N];
  div_ctl_t         dv_ctl_r [DIV_N];
  logic [DEN_W-1:0] dv_rem_r [DIV_N];
  logic [QUO_W-1:0] dv_q_r   [DIV_N];
  logic [QUO_W-1:0] dv_nlo_r [DIV_N];

  for (genvar k = 0; k < DIV_N; k++) begin : g_div
    logic             vld_i, ge;
    div_ctl_t         ctl_i;
    logic [DEN_W-1:0] rem_i;
    logic [QUO_W-1:0] q_i, nlo_i;
    logic [DEN_W:0]   rem2, diff;
    if (k == 0) begin : g_first
      assign vld_i = b_vld_r;
      assign ctl_i = b_ctl_r;
      assign rem_i = b_rem_r;
      assign q_i   = '0;
      assign nlo_i = b_nlo_r;
    end else begin : g_next
      assign vld_i = dv_vld_r[k-1];
      assign ctl_i = dv_ctl_r[k-1];
      assign rem_i = dv_rem_r[k-1];
      assign q_i   = dv_q_r[k-1];
      assign nlo_i = dv_nlo_r[k-1];
    end
    assign rem2 = {rem_i, nlo_i[QUO_W-1]};
    assign diff = rem2 - {1'b0, ctl_i.den};
    assign ge   = rem2 >= {1'b0, ctl_i.den};
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_vld_r[k] <= 1'b0;
      end else begin
        dv_vld_r[k] <= vld_i;
      end
    end
    always_ff @(posedge clk) begin
      dv_ctl_r[k] <= ctl_i;
      dv_rem_r[k] <= ge ? diff[DEN_W-1:0] : rem2[DEN_W-1:0];
      dv_q_r[k]   <= {q_i[QUO_W-2:0], ge};
      dv_nlo_r[k] <= {nlo_i[QUO_W-2:0], 1'b0};
    end
  end

  // sign and saturation
  logic                 out_vld_r;
  logic signed [31:0]   time_r;
  logic signed [31:0]   time_nxt;
  ttc_pkg::ttc_status_t status_r;
  div_ctl_t             fin;
  logic [QUO_W-1:0]     q;

  assign fin = dv_ctl_r[DIV_N-1];
  assign q   = dv_q_r[DIV_N-1];

  always_comb begin
    if (!fin.do_div) begin
      time_nxt = 32'sd0;
    end else if (fin.neg) begin
      time_nxt = (fin.ovf || (q[31] && |q[30:0])) ? 32'sh80000000 : $signed(32'd0 - q);
    end else begin
      time_nxt = (fin.ovf || q[31]) ? 32'sh7FFFFFFF : $signed(q);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= dv_vld_r[DIV_N-1];
    end
  end

  always_ff @(posedge clk) begin
    time_r   <= time_nxt;
    status_r <= fin.status;
  end

  assign res_vld    = out_vld_r;
  assign res_time   = time_r;
  assign res_status = status_r;

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for time_to_collision_two_agents_top: directed table,
// then random agent pairs over several collision distances, with a predictor.
// Depends on ttc_pkg and the RTL of the time-to-collision pipeline.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY     = 107;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic signed [31:0] own_x, own_y, oth_x, oth_y;
    logic [23:0]        own_spd, oth_spd;
    logic [15:0]        own_hd, oth_hd;
  } pair_t;

  typedef struct {
    logic signed [31:0]   ttc;
    ttc_pkg::ttc_status_t status;
  } ttc_res_t;

  typedef struct {
    logic [23:0] cd;
    pair_t       p;
    logic        known;
    ttc_res_t    res;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [31:0] in_own_x = '0, in_own_y = '0, in_other_x = '0, in_other_y = '0;
  logic [23:0] in_own_speed = '0, in_other_speed = '0;
  logic [15:0] in_own_heading = '0, in_other_heading = '0;
  logic out_valid;
  logic signed [31:0] out_collision_time;
  logic [1:0] out_ttc_status;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [23:0] cfg_collision_distance = '0;

  logic [23:0] dist_q = '0;
  ttc_res_t    pending_ttc[$];
  int          errors = 0;
  int          cycles = 0;
  pair_t       cur_pair;

  time_to_collision_two_agents_top u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_own_x(in_own_x), .in_own_y(in_own_y), .in_own_speed(in_own_speed),
    .in_own_heading(in_own_heading), .in_other_x(in_other_x), .in_other_y(in_other_y),
    .in_other_speed(in_other_speed), .in_other_heading(in_other_heading),
    .out_valid(out_valid), .out_collision_time(out_collision_time),
    .out_ttc_status(out_ttc_status), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_collision_distance(cfg_collision_distance)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------- predictor ----------------
  function automatic longint unsigned quarter_wave(longint unsigned x);
    longint unsigned x30, x2, t1, t2;
    x30 = x << 16;
    x2  = (x30 * x30) >> 30;
    t1  = 64'(ttc_pkg::SIN_B) - ((64'(ttc_pkg::SIN_C) * x2) >> 30);
    t2  = 64'(ttc_pkg::SIN_A) - ((x2 * t1) >> 30);
    return (x30 * t2) >> 30;
  endfunction

  function automatic longint sine_turn(logic [15:0] turn);
    logic [1:0] quad;
    longint unsigned f, m;
    quad = turn[15:14];
    f = 64'(turn[13:0]);
    m = quarter_wave(quad[0] ? 64'd16384 - f : f);
    return quad[1] ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint vel_comp(logic [23:0] spd, longint trig);
    longint unsigned m, v;
    m = (trig < 0) ? longint'(-trig) : longint'(trig);
    v = (64'(spd) * m) >> 30;
    return (trig < 0) ? -longint'(v) : longint'(v);
  endfunction

  function automatic longint pos_delta(logic signed [31:0] own, logic signed [31:0] oth);
    longint d;
    d = longint'(oth) - longint'(own);
    if (d > 64'sd2147483647) d = 64'sd2147483647;
    if (d < -64'sd2147483647) d = -64'sd2147483647;
    return d;
  endfunction

  function automatic logic signed [31:0] clamp_time(logic [129:0] mag, logic neg);
    if (neg) return (mag > 130'd2147483648) ? 32'sh8000_0000 : -32'(mag);
    return (mag > 130'd2147483647) ? 32'sh7FFF_FFFF : 32'(mag);
  endfunction

  function automatic ttc_res_t predict_ttc(pair_t p, logic [23:0] cd);
    ttc_res_t r;
    logic signed [129:0] sdx, sdy, sdvx, sdvy, scd, a, h, c, disc;
    logic [129:0] habs, cabs, root, cand;
    sdx  = pos_delta(p.own_x, p.oth_x);
    sdy  = pos_delta(p.own_y, p.oth_y);
    sdvx = vel_comp(p.oth_spd, sine_turn(p.oth_hd + 16'd16384))
         - vel_comp(p.own_spd, sine_turn(p.own_hd + 16'd16384));
    sdvy = vel_comp(p.oth_spd, sine_turn(p.oth_hd)) - vel_comp(p.own_spd, sine_turn(p.own_hd));
    scd  = 130'(cd);
    a    = sdvx * sdvx + sdvy * sdvy;
    h    = sdx * sdvx + sdy * sdvy;
    c    = sdx * sdx + sdy * sdy - scd * scd;
    habs = (h < 0) ? -h : h;
    cabs = (c < 0) ? -c : c;
    r.ttc = '0;
    r.status = ttc_pkg::ST_NONE;
    if (a == 0) begin
      if (h != 0) begin
        r.ttc = clamp_time((cabs << 16) / (2 * habs), c != 0 && ((c > 0) == (h > 0)));
        r.status = ttc_pkg::ST_FINITE;
      end
    end else begin
      disc = h * h - a * c;
      if (disc == 0) begin
        r.ttc = clamp_time((habs << 16) / a, h > 0);
        r.status = ttc_pkg::ST_FINITE;
      end else if (disc > 0) begin
        if (h > 0 && c > 0) r.status = ttc_pkg::ST_NONE;
        else if (h >= 0 || c < 0) r.status = ttc_pkg::ST_NOW;
        else begin
          root = '0;
          for (int i = 58; i >= 0; i--) begin
            cand = root | (130'd1 << i);
            if (cand * cand <= disc) root = cand;
          end
          r.ttc = clamp_time((cabs << 16) / (habs + root), 1'b0);
          r.status = ttc_pkg::ST_FINITE;
        end
      end
    end
    return r;
  endfunction

  // ---------------- monitor ----------------
  always @(posedge clk) begin
    ttc_res_t want;
    if (rst_n) begin
      if (start && !busy) pending_ttc.push_back(predict_ttc(cur_pair, dist_q));
      if (out_valid) begin
        if (pending_ttc.size() == 0) begin
          $error("unexpected result: time %0d status %0d", out_collision_time, out_ttc_status);
          errors++;
        end else begin
          want = pending_ttc.pop_front();
          if (out_collision_time !== want.ttc) begin
            $error("collision_time: expected %0d, got %0d", want.ttc, out_collision_time);
            errors++;
          end
          if (out_ttc_status !== want.status) begin
            $error("ttc_status: expected %0d, got %0d", want.status, out_ttc_status);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // ---------------- driver ----------------
  task automatic send_request(pair_t p);
    start <= 1'b1;
    in_own_x <= p.own_x; in_own_y <= p.own_y;
    in_own_speed <= p.own_spd; in_own_heading <= p.own_hd;
    in_other_x <= p.oth_x; in_other_y <= p.oth_y;
    in_other_speed <= p.oth_spd; in_other_heading <= p.oth_hd;
    cur_pair <= p;
    do @(posedge clk); while (busy);
  endtask

  task automatic idle_cycle();
    start <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_distance(logic [23:0] d);
    start <= 1'b0;
    while (pending_ttc.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_collision_distance <= d;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    dist_q = d;
  endtask

  function automatic logic signed [31:0] rand_pos(bit wide_range);
    if (wide_range) return $urandom;
    return $signed($urandom_range(0, 32'h01FF_FFFF)) - 32'sh0100_0000;
  endfunction

  function automatic pair_t rand_pair();
    pair_t p;
    bit w;
    w = ($urandom_range(0, 9) == 0);
    p.own_x = rand_pos(w); p.own_y = rand_pos(w);
    p.oth_x = rand_pos(w); p.oth_y = rand_pos(w);
    p.own_spd = ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($urandom_range(0, 24'h3F_FFFF));
    p.oth_spd = ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($urandom_range(0, 24'h3F_FFFF));
    p.own_hd = $urandom;
    p.oth_hd = $urandom;
    if ($urandom_range(0, 7) == 0) p.oth_spd = '0;
    return p;
  endfunction

  row_t rows[] = '{
    '{24'd0,        '{32'sd0, 32'sd0, 32'sd0, 32'sd0, 24'd0, 24'd0, 16'd0, 16'd0},
      1'b1, '{32'sd0, ttc_pkg::ST_NONE}},
    '{24'd0,        '{32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
      24'hFF_FFFF, 24'hFF_FFFF, 16'd0, 16'd0}, 1'b1, '{32'sd0, ttc_pkg::ST_NONE}},
    '{24'd0,        '{32'sd0, 32'sd0, 32'sd655360, 32'sd0, 24'd65536, 24'd65536,
      16'd0, 16'd32768}, 1'b0, '{32'sd0, ttc_pkg::ST_NONE}},
    '{24'd0,        '{32'sh7FFF_FFFF, 32'sd0, 32'sh8000_0000, 32'sd0, 24'hFF_FFFF, 24'd0,
      16'd32768, 16'hFFFF}, 1'b0, '{32'sd0, ttc_pkg::ST_NONE}},
    '{24'd131072,   '{32'sd0, 32'sd0, 32'sd65536, 32'sd0, 24'd65536, 24'd0,
      16'd32768, 16'd0}, 1'b0, '{32'sd0, ttc_pkg::ST_NONE}},
    '{24'd131072,   '{32'sd0, 32'sd0, 32'sd65536, 32'sd0, 24'd65536, 24'd0,
      16'd0, 16'd0}, 1'b0, '{32'sd0, ttc_pkg::ST_NONE}},
    '{24'd131072,   '{32'sd0, 32'sd0, 32'sd6553600, 32'sd0, 24'd65536, 24'd0,
      16'd32768, 16'd0}, 1'b0, '{32'sd0, ttc_pkg::ST_NONE}},
    '{24'd131072,   '{32'sd0, 32'sd6553600, 32'sd6553600, 32'sd6553600, 24'd65536, 24'd65536,
      16'd0, 16'd32768}, 1'b0, '{32'sd0, ttc_pkg::ST_NONE}},
    '{24'd131072,   '{32'sd0, 32'sd0, 32'sd6553600, 32'sd6553600, 24'd65536, 24'd0,
      16'd0, 16'd0}, 1'b0, '{32'sd0, ttc_pkg::ST_NONE}},
    '{24'hFF_FFFF,  '{32'sd0, 32'sd0, 32'sd0, 32'sd0, 24'd0, 24'd0, 16'hFFFF, 16'hFFFF},
      1'b0, '{32'sd0, ttc_pkg::ST_NONE}},
    '{24'hFF_FFFF,  '{32'sh8000_0000, 32'sd0, 32'sh7FFF_FFFF, 32'sd0, 24'd65536, 24'hFF_FFFF,
      16'd16384, 16'd49152}, 1'b0, '{32'sd0, ttc_pkg::ST_NONE}},
    '{24'hFF_FFFF,  '{32'sd0, 32'sd0, 32'sd1, 32'sd1, 24'd1, 24'd1, 16'd8192, 16'd40960},
      1'b0, '{32'sd0, ttc_pkg::ST_NONE}},
    '{24'd1,        '{32'sd0, 32'sd0, 32'sh7FFF_0000, 32'sd0, 24'd1, 24'd0,
      16'd0, 16'd0}, 1'b0, '{32'sd0, ttc_pkg::ST_NONE}},
    '{24'd1,        '{32'sd5, 32'sd7, 32'sd5, 32'sd7, 24'd300, 24'd300, 16'd1234, 16'd1234},
      1'b1, '{32'sd0, ttc_pkg::ST_NONE}}
  };

  logic [23:0] phase_dist[6] = '{24'd0, 24'hFF_FFFF, 24'd65536, 24'd1, 24'h00_4000, 24'h12_3456};

  initial begin
    bit calm;
    ttc_res_t chk;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      if (rows[i].cd != dist_q) set_distance(rows[i].cd);
      if (rows[i].known) begin
        chk = predict_ttc(rows[i].p, rows[i].cd);
        if (chk.ttc !== rows[i].res.ttc) begin
          $error("table row %0d collision_time: expected %0d, got %0d",
                 i, rows[i].res.ttc, chk.ttc);
          errors++;
        end
        if (chk.status !== rows[i].res.status) begin
          $error("table row %0d ttc_status: expected %0d, got %0d",
                 i, rows[i].res.status, chk.status);
          errors++;
        end
      end
      send_request(rows[i].p);
      if ($urandom_range(0, 99) < 12) idle_cycle();
    end

    for (int ph = 0; ph < 6; ph++) begin
      set_distance((ph == 5) ? 24'($urandom) : phase_dist[ph]);
      for (int n = 0; n < 200; n++) begin
        calm = (ph == 2);
        while (!calm && $urandom_range(0, 99) < 12) idle_cycle();
        send_request(rand_pair());
      end
    end
    start <= 1'b0;

    while (pending_ttc.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0) $display("testbench: PASS");
    else $display("testbench: FAIL");
    $finish;
  end
endmodule
